FILE: rtl/mqf_pkg.sv
// ============================================================================
// MHD quality factor package
// Shared types and constants for the per-cell quality factor pipeline.
// ============================================================================
`default_nettype none

package mqf_pkg;

    // Field and register widths
    localparam int DATA_W = 32;
    localparam int ADI_W  = 19;
    localparam int CW_W   = 31;
    localparam int CFG_W  = 31;

    // Saturation limits of a signed 32-bit value
    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // 2*pi with 32 fractional bits; rounded to nearest at the working precision
    localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

    // Register reset values
    localparam logic [ADI_W-1:0] ADI_RESET = 19'd87381;
    localparam logic [CW_W-1:0]  CW_RESET  = 31'd65536;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEAT_RATIO = 1'b0,
        CFG_CELL_WIDTH = 1'b1
    } cfg_index_t;

    // Pipeline control handed to each arithmetic unit
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mhd_q_factor_cell_core.sv
// Throughput: one cell per cycle while the output skid stage is empty; the two
//   dividers and the square roots resolve one bit per stage, so their depth sets
//   the latency and not the rate.
// Reset: asynchronous, active low; clears all valid bits and the output skid stage and
//   loads heat_ratio = 87381 and cell_width = 65536.
// ============================================================================
// MHD cell quality factor core
// Streams cells in, computes the Lorentz factor, field strength and enthalpy,
// and returns the saturated resolution quality factor with an invalid flag.
// ============================================================================
`default_nettype none

module mhd_q_factor_cell_core
    import mqf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration write port
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    // Cell input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // velocity_one, velocity_two, velocity_three, field_one, field_two,
    // field_three, mass_density, internal_energy (32 bits each, lowest first)
    input  wire logic [255:0]      s_tdata,
    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // quality [31:0]
    output logic [31:0]            m_tdata,
    // invalid [0]
    output logic [0:0]             m_tuser
);

    localparam int GX_W = 2 * ((32 + FRAC_BITS) / 2);
    localparam int R_W  = GX_W / 2;
    localparam int D1_W = 31 + FRAC_BITS;
    localparam int D2_W = 32 + FRAC_BITS;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic [63:0] TWO_PI_W =
        (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [31:0] TWO_PI = signed'(TWO_PI_W[31:0]);

    localparam int P1_W = 31 + 4 * DATA_W;
    localparam int PE_W = 1 + 2 * DATA_W;

    // Clamp a wide signed value into 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff)
            r = SAT_MAX;
        else if (v < 64'shffff_ffff_8000_0000)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // Fixed-point product, round half up, saturate
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat32((p + HALF) >>> FRAC_BITS);
    endfunction

    // Saturated sum of three
    function automatic logic signed [31:0] sum3(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z);
        return sat32(64'(x) + 64'(y) + 64'(z));
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADI_W-1:0] heat_ratio_reg;
    logic [CW_W-1:0]  cell_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_ratio_reg <= ADI_RESET;
            cell_width_reg <= CW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEAT_RATIO: heat_ratio_reg <= cfg_data[ADI_W-1:0];
                CFG_CELL_WIDTH: cell_width_reg <= cfg_data[CW_W-1:0];
                default:        ;
            endcase
        end
    end

    logic signed [31:0] adi_s;
    logic signed [31:0] cw_s;
    assign adi_s = signed'(32'(heat_ratio_reg));
    assign cw_s  = signed'(32'(cell_width_reg));

    // ------------------------------------------------------------------
    // Global stall: the whole pipeline holds while the skid stage is full
    // ------------------------------------------------------------------
    logic      en;
    logic      skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Unpack the input beat
    logic signed [31:0] vel1, vel2, vel3, fld1, fld2, fld3, rho, eny;
    assign vel1 = signed'(s_tdata[31:0]);
    assign vel2 = signed'(s_tdata[63:32]);
    assign vel3 = signed'(s_tdata[95:64]);
    assign fld1 = signed'(s_tdata[127:96]);
    assign fld2 = signed'(s_tdata[159:128]);
    assign fld3 = signed'(s_tdata[191:160]);
    assign rho  = signed'(s_tdata[223:192]);
    assign eny  = signed'(s_tdata[255:224]);

    // ------------------------------------------------------------------
    // Stage A: all first-level products
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic signed [31:0] a_uu1_reg, a_uu2_reg, a_uu3_reg;
    logic signed [31:0] a_bb1_reg, a_bb2_reg, a_bb3_reg;
    logic signed [31:0] a_ub1_reg, a_ub2_reg, a_ub3_reg;
    logic signed [31:0] a_grho_reg, a_eny_reg, a_u2_reg, a_f2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_uu1_reg  <= mulq(vel1, vel1);
            a_uu2_reg  <= mulq(vel2, vel2);
            a_uu3_reg  <= mulq(vel3, vel3);
            a_bb1_reg  <= mulq(fld1, fld1);
            a_bb2_reg  <= mulq(fld2, fld2);
            a_bb3_reg  <= mulq(fld3, fld3);
            a_ub1_reg  <= mulq(vel1, fld1);
            a_ub2_reg  <= mulq(vel2, fld2);
            a_ub3_reg  <= mulq(vel3, fld3);
            a_grho_reg <= mulq(adi_s, rho);
            a_eny_reg  <= eny;
            a_u2_reg   <= vel2;
            a_f2_reg   <= fld2;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: dot products, 1+u^2 and enthalpy
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic signed [31:0] b_g2_reg, b_bb_reg, b_ub_reg, b_h_reg, b_u2_reg, b_f2_reg;
    logic signed [31:0] b_uu_next;

    assign b_uu_next = sum3(a_uu1_reg, a_uu2_reg, a_uu3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_g2_reg <= sat32(64'(ONE) + 64'(b_uu_next));
            b_bb_reg <= sum3(a_bb1_reg, a_bb2_reg, a_bb3_reg);
            b_ub_reg <= sum3(a_ub1_reg, a_ub2_reg, a_ub3_reg);
            b_h_reg  <= sat32(64'(a_eny_reg) + 64'(a_grho_reg));
            b_u2_reg <= a_u2_reg;
            b_f2_reg <= a_f2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: (u.B)^2
    // ------------------------------------------------------------------
    logic               c_valid_reg;
    logic signed [31:0] c_ubub_reg, c_g2_reg, c_bb_reg, c_ub_reg, c_h_reg;
    logic signed [31:0] c_u2_reg, c_f2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ubub_reg <= mulq(b_ub_reg, b_ub_reg);
            c_g2_reg   <= b_g2_reg;
            c_bb_reg   <= b_bb_reg;
            c_ub_reg   <= b_ub_reg;
            c_h_reg    <= b_h_reg;
            c_u2_reg   <= b_u2_reg;
            c_f2_reg   <= b_f2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: numerator of b^2 (never negative)
    // ------------------------------------------------------------------
    logic               d_valid_reg;
    logic signed [31:0] d_bbub_reg, d_g2_reg, d_ub_reg, d_h_reg, d_u2_reg, d_f2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_bbub_reg <= sat32(64'(c_bb_reg) + 64'(c_ubub_reg));
            d_g2_reg   <= c_g2_reg;
            d_ub_reg   <= c_ub_reg;
            d_h_reg    <= c_h_reg;
            d_u2_reg   <= c_u2_reg;
            d_f2_reg   <= c_f2_reg;
        end
    end

    // ------------------------------------------------------------------
    // b^2 divider: g2 >= 1.0, so the quotient stays below 2^31
    // ------------------------------------------------------------------
    pipe_ctl_t          div1_ctl;
    logic               div1_valid;
    logic [D1_W-1:0]    div1_q;
    logic [P1_W-1:0]    div1_pass;

    assign div1_ctl.en    = en;
    assign div1_ctl.valid = d_valid_reg;

    mqf_div #(
        .NUM_W  (D1_W),
        .DEN_W  (31),
        .PASS_W (P1_W)
    ) u_div_bsq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div1_ctl),
        .dividend  (D1_W'(d_bbub_reg[30:0]) << FRAC_BITS),
        .divisor   (d_g2_reg[30:0]),
        .pass_in   ({d_g2_reg[30:0], d_h_reg, d_u2_reg, d_f2_reg, d_ub_reg}),
        .valid_out (div1_valid),
        .quotient  (div1_q),
        .pass_out  (div1_pass)
    );

    // ------------------------------------------------------------------
    // Stage E: radicand b^2 + h
    // ------------------------------------------------------------------
    logic               e_valid_reg;
    logic signed [31:0] e_e_reg, e_ub_reg, e_u2_reg, e_f2_reg;
    logic [30:0]        e_g2_reg;
    logic signed [31:0] e_bsq;

    assign e_bsq = signed'(32'(div1_q[30:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en)
            e_valid_reg <= div1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_e_reg  <= sat32(64'(e_bsq) + 64'(signed'(div1_pass[127:96])));
            e_g2_reg <= div1_pass[P1_W-1:128];
            e_u2_reg <= signed'(div1_pass[95:64]);
            e_f2_reg <= signed'(div1_pass[63:32]);
            e_ub_reg <= signed'(div1_pass[31:0]);
        end
    end

    // ------------------------------------------------------------------
    // Square roots of the radicand and of 1+u^2, side by side
    // ------------------------------------------------------------------
    pipe_ctl_t          sq_ctl;
    logic               e_neg;
    logic [GX_W-1:0]    sqe_in;
    logic               sqe_valid, sqg_valid;
    logic [R_W-1:0]     sqe_root, sqg_root;
    logic [PE_W-1:0]    sqe_pass;
    logic [DATA_W-1:0]  sqg_pass;

    assign sq_ctl.en    = en;
    assign sq_ctl.valid = e_valid_reg;
    assign e_neg        = e_e_reg[31];
    assign sqe_in       = e_neg ? '0 : (GX_W'(e_e_reg[30:0]) << FRAC_BITS);

    mqf_sqrt #(
        .IN_W   (GX_W),
        .PASS_W (PE_W)
    ) u_sqrt_e (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .radicand  (sqe_in),
        .pass_in   ({e_neg, e_u2_reg, e_f2_reg}),
        .valid_out (sqe_valid),
        .root      (sqe_root),
        .pass_out  (sqe_pass)
    );

    mqf_sqrt #(
        .IN_W   (GX_W),
        .PASS_W (DATA_W)
    ) u_sqrt_g (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .radicand  (GX_W'(e_g2_reg) << FRAC_BITS),
        .pass_in   (e_ub_reg),
        .valid_out (sqg_valid),
        .root      (sqg_root),
        .pass_out  (sqg_pass)
    );

    logic signed [31:0] gl, se, f_u2, f_f2, f_ub;
    assign gl   = signed'(32'(sqg_root));
    assign se   = signed'(32'(sqe_root));
    assign f_u2 = signed'(sqe_pass[63:32]);
    assign f_f2 = signed'(sqe_pass[31:0]);
    assign f_ub = signed'(sqg_pass);

    // ------------------------------------------------------------------
    // Stage G: products with the Lorentz factor
    // ------------------------------------------------------------------
    logic               g_valid_reg;
    logic signed [31:0] g_t1_reg, g_t2_reg, g_glu_reg, g_se_reg;
    logic               g_einv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (en)
            g_valid_reg <= sqe_valid & sqg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_t1_reg   <= mulq(gl, f_f2);
            g_t2_reg   <= mulq(f_ub, f_u2);
            g_glu_reg  <= mulq(gl, f_u2);
            g_se_reg   <= se;
            g_einv_reg <= sqe_pass[PE_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage H: numerator sum, first denominator product
    // ------------------------------------------------------------------
    logic               h_valid_reg;
    logic signed [31:0] h_s_reg, h_d1_reg;
    logic               h_einv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (en)
            h_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_s_reg    <= sat32(64'(g_t1_reg) + 64'(g_t2_reg));
            h_d1_reg   <= mulq(g_glu_reg, g_se_reg);
            h_einv_reg <= g_einv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage I: scale by 2*pi and by the cell width
    // ------------------------------------------------------------------
    logic               i_valid_reg;
    logic signed [31:0] i_num_reg, i_den_reg;
    logic               i_einv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_valid_reg <= 1'b0;
        else if (en)
            i_valid_reg <= h_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_num_reg  <= mulq(TWO_PI, h_s_reg);
            i_den_reg  <= mulq(h_d1_reg, cw_s);
            i_einv_reg <= h_einv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage J: flag bad cells, take magnitudes for the final divider
    // ------------------------------------------------------------------
    logic               j_valid_reg;
    logic [31:0]        j_nmag_reg, j_dmag_reg;
    logic               j_inv_reg, j_nneg_reg, j_qneg_reg;
    logic               j_inv_next;

    assign j_inv_next = i_einv_reg | (i_den_reg == 32'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_valid_reg <= 1'b0;
        else if (en)
            j_valid_reg <= i_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_nmag_reg <= i_num_reg[31] ? (~i_num_reg + 32'd1) : i_num_reg;
            // A bad cell divides by one so the unit never sees zero
            j_dmag_reg <= j_inv_next   ? 32'd1
                        : i_den_reg[31] ? (~i_den_reg + 32'd1) : i_den_reg;
            j_inv_reg  <= j_inv_next;
            j_nneg_reg <= i_num_reg[31];
            j_qneg_reg <= i_num_reg[31] ^ i_den_reg[31];
        end
    end

    // ------------------------------------------------------------------
    // Final divider
    // ------------------------------------------------------------------
    pipe_ctl_t          div2_ctl;
    logic               div2_valid;
    logic [D2_W-1:0]    div2_q;
    logic [2:0]         div2_pass;

    assign div2_ctl.en    = en;
    assign div2_ctl.valid = j_valid_reg;

    mqf_div #(
        .NUM_W  (D2_W),
        .DEN_W  (32),
        .PASS_W (3)
    ) u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div2_ctl),
        .dividend  (D2_W'(j_nmag_reg) << FRAC_BITS),
        .divisor   (j_dmag_reg),
        .pass_in   ({j_inv_reg, j_nneg_reg, j_qneg_reg}),
        .valid_out (div2_valid),
        .quotient  (div2_q),
        .pass_out  (div2_pass)
    );

    // Apply sign and saturate the quotient
    logic [31:0] res_q;
    logic        res_inv;

    always_comb
    begin
        res_inv = div2_pass[2];
        priority if (div2_pass[2])
            res_q = div2_pass[1] ? SAT_MIN : SAT_MAX;
        else if (div2_pass[0])
            res_q = (div2_q > (D2_W'(1) << 31)) ? SAT_MIN : (32'd0 - div2_q[31:0]);
        else
            res_q = ((div2_q >> 31) != '0) ? SAT_MAX : div2_q[31:0];
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    logic [31:0] out_q_reg, skid_q_reg;
    logic        out_inv_reg, skid_inv_reg;
    logic        produce;
    logic        out_free;

    assign produce  = en & div2_valid;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Drain the skid beat first
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= produce;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_q_reg   <= skid_q_reg;
                out_inv_reg <= skid_inv_reg;
            end
        end
        else if (out_free)
        begin
            out_q_reg   <= res_q;
            out_inv_reg <= res_inv;
        end
        else
        begin
            skid_q_reg   <= res_q;
            skid_inv_reg <= res_inv;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_q_reg;
    assign m_tuser  = out_inv_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the output is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> !skid_valid_reg)
        else $error("skid stage did not drain after the output moved");

    a_invalid_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == SAT_MAX || m_tdata == SAT_MIN))
        else $error("invalid result is not saturated");

    a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        sqe_valid == sqg_valid)
        else $error("square root units out of step");

endmodule

`default_nettype wire

FILE: rtl/mqf_sqrt.sv
// ============================================================================
// Pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage,
// with a side payload that travels alongside.
// ============================================================================
`default_nettype none

module mqf_sqrt
    import mqf_pkg::*;
#(
    parameter int IN_W   = 48,
    parameter int PASS_W = 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pipe_ctl_t           ctl,
    input  wire logic [IN_W-1:0]     radicand,
    input  wire logic [PASS_W-1:0]   pass_in,
    output logic                     valid_out,
    output logic [IN_W/2-1:0]        root,
    output logic [PASS_W-1:0]        pass_out
);

    localparam int R_W   = IN_W / 2;
    localparam int REM_W = R_W + 2;

    logic              valid_reg [R_W];
    logic [IN_W-1:0]   x_reg     [R_W];
    logic [REM_W-1:0]  rem_reg   [R_W];
    logic [R_W-1:0]    root_reg  [R_W];
    logic [PASS_W-1:0] pass_reg  [R_W];

    for (genvar s = 0; s < R_W; s++) begin : g_stage
        logic              prev_v;
        logic [IN_W-1:0]   prev_x;
        logic [REM_W-1:0]  prev_rem;
        logic [R_W-1:0]    prev_root;
        logic [PASS_W-1:0] prev_pass;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              fits;
        logic [REM_W-1:0]  rem_next;
        logic [R_W-1:0]    root_next;
        logic [IN_W-1:0]   x_next;

        // Select the stage input
        if (s == 0) begin : g_first
            assign prev_v    = ctl.valid;
            assign prev_x    = radicand;
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_pass = pass_in;
        end
        else begin : g_rest
            assign prev_v    = valid_reg[s-1];
            assign prev_x    = x_reg[s-1];
            assign prev_rem  = rem_reg[s-1];
            assign prev_root = root_reg[s-1];
            assign prev_pass = pass_reg[s-1];
        end

        // Bring down two radicand bits and try the next root bit
        always_comb
        begin
            rem_sh    = {prev_rem[REM_W-3:0], prev_x[IN_W-1 -: 2]};
            trial     = {prev_root, 2'b01};
            fits      = (rem_sh >= trial);
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {prev_root[R_W-2:0], fits};
            x_next    = {prev_x[IN_W-3:0], 2'b00};
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (ctl.en)
            begin
                valid_reg[s] <= prev_v;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                x_reg[s]    <= x_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                pass_reg[s] <= prev_pass;
            end
        end
    end

    assign valid_out = valid_reg[R_W-1];
    assign root      = root_reg[R_W-1];
    assign pass_out  = pass_reg[R_W-1];

endmodule

`default_nettype wire

FILE: rtl/mqf_div.sv
// ============================================================================
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a side
// payload that travels alongside. The divisor must be nonzero.
// ============================================================================
`default_nettype none

module mqf_div
    import mqf_pkg::*;
#(
    parameter int NUM_W  = 47,
    parameter int DEN_W  = 31,
    parameter int PASS_W = 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pipe_ctl_t           ctl,
    input  wire logic [NUM_W-1:0]    dividend,
    input  wire logic [DEN_W-1:0]    divisor,
    input  wire logic [PASS_W-1:0]   pass_in,
    output logic                     valid_out,
    output logic [NUM_W-1:0]         quotient,
    output logic [PASS_W-1:0]        pass_out
);

    logic              valid_reg [NUM_W];
    logic [NUM_W-1:0]  n_reg     [NUM_W];
    logic [NUM_W-1:0]  q_reg     [NUM_W];
    logic [DEN_W-1:0]  r_reg     [NUM_W];
    logic [DEN_W-1:0]  d_reg     [NUM_W];
    logic [PASS_W-1:0] pass_reg  [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic              prev_v;
        logic [NUM_W-1:0]  prev_n;
        logic [NUM_W-1:0]  prev_q;
        logic [DEN_W-1:0]  prev_r;
        logic [DEN_W-1:0]  prev_d;
        logic [PASS_W-1:0] prev_pass;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              fits;
        logic [DEN_W-1:0]  r_next;
        logic [NUM_W-1:0]  q_next;
        logic [NUM_W-1:0]  n_next;

        // Select the stage input
        if (s == 0) begin : g_first
            assign prev_v    = ctl.valid;
            assign prev_n    = dividend;
            assign prev_q    = '0;
            assign prev_r    = '0;
            assign prev_d    = divisor;
            assign prev_pass = pass_in;
        end
        else begin : g_rest
            assign prev_v    = valid_reg[s-1];
            assign prev_n    = n_reg[s-1];
            assign prev_q    = q_reg[s-1];
            assign prev_r    = r_reg[s-1];
            assign prev_d    = d_reg[s-1];
            assign prev_pass = pass_reg[s-1];
        end

        // Shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            trial  = {prev_r, prev_n[NUM_W-1]};
            diff   = trial - {1'b0, prev_d};
            fits   = (trial >= {1'b0, prev_d});
            r_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next = {prev_q[NUM_W-2:0], fits};
            n_next = {prev_n[NUM_W-2:0], 1'b0};
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (ctl.en)
            begin
                valid_reg[s] <= prev_v;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                n_reg[s]    <= n_next;
                q_reg[s]    <= q_next;
                r_reg[s]    <= r_next;
                d_reg[s]    <= prev_d;
                pass_reg[s] <= prev_pass;
            end
        end
    end

    assign valid_out = valid_reg[NUM_W-1];
    assign quotient  = q_reg[NUM_W-1];
    assign pass_out  = pass_reg[NUM_W-1];

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MHD cell quality factor core testbench
// Streams cells with directed corner values and random content through the
// core under several register settings and idle patterns, predicts each
// quality factor and invalid flag in fixed point, and checks every result beat.
// ----------------------------------------------------------------------------

import mqf_pkg::*;

// Expected quality factors of accepted cells, oldest first
class q_factor_board;
    localparam int FB = 16;
    logic [ADI_W-1:0] gamma;
    logic [CW_W-1:0]  width;
    logic [32:0]      pending[$];
    int               errors;

    function new();
        gamma  = ADI_RESET;
        width  = CW_RESET;
        errors = 0;
    endfunction

    static function longint clamp(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Round to nearest with ties up: floor of (p + half) / one
    static function longint fx_mul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FB - 1));
        return clamp(p >>> FB);
    endfunction

    static function longint fx_div(longint a, longint d);
        return clamp((a * (64'sd1 <<< FB)) / d);
    endfunction

    static function longint fx_root(longint v);
        longint unsigned x, res, bitv;
        x    = longint'(v) << FB;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function void note_cell(logic [255:0] d);
        longint f[8];
        longint two_pi, uu, g2, gl, bb, ub, bsq, h, e, num, den, q;
        logic   bad;
        for (int i = 0; i < 8; i++)
            f[i] = longint'($signed(d[32*i +: 32]));
        two_pi = longint'((TWO_PI_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
        uu  = clamp(fx_mul(f[0], f[0]) + fx_mul(f[1], f[1]) + fx_mul(f[2], f[2]));
        g2  = clamp((64'sd1 <<< FB) + uu);
        gl  = fx_root(g2);
        bb  = clamp(fx_mul(f[3], f[3]) + fx_mul(f[4], f[4]) + fx_mul(f[5], f[5]));
        ub  = clamp(fx_mul(f[0], f[3]) + fx_mul(f[1], f[4]) + fx_mul(f[2], f[5]));
        bsq = fx_div(clamp(bb + fx_mul(ub, ub)), g2);
        h   = clamp(f[7] + fx_mul(longint'(gamma), f[6]));
        e   = clamp(bsq + h);
        num = fx_mul(two_pi, clamp(fx_mul(gl, f[4]) + fx_mul(ub, f[1])));
        bad = 1'b0;
        den = 0;
        if (e < 0)
            bad = 1'b1;
        else
        begin
            den = fx_mul(fx_mul(fx_mul(gl, f[1]), fx_root(e)), longint'(width));
            if (den == 0)
                bad = 1'b1;
        end
        if (bad)
            q = (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        else
            q = fx_div(num, den);
        pending.push_back({bad, q[31:0]});
    endfunction

    function void check_result(logic [31:0] q, logic bad);
        logic [32:0] want;
        if (pending.size() == 0)
        begin
            $error("result beat with no cell outstanding: quality %h invalid %b", q, bad);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (q !== want[31:0])
        begin
            $error("quality: expected %h, actual %h", want[31:0], q);
            errors++;
        end
        if (bad !== want[32])
        begin
            $error("invalid: expected %b, actual %b", want[32], bad);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int WATCH_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [0:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [255:0]     s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;
    logic [0:0]       m_tuser;

    q_factor_board board = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;

    always #5 clk = ~clk;

    mhd_q_factor_cell_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Note accepted cells, check result beats, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_cell(s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser[0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Drive result backpressure; hold off once for a long stretch on request
    always @(posedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Offer one cell and hold it until accepted, with random gaps after
    task automatic send_cell(logic [255:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Leave the write enable high; the caller drops it after the last write
    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_HEAT_RATIO)
            board.gamma = val[ADI_W-1:0];
        else
            board.width = val[CW_W-1:0];
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'($urandom_range(0, 524288)) - 32'd262144;
            5:             return 32'($urandom_range(0, 33554432)) - 32'd16777216;
            6:             return $urandom();
            7:             return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            8:             return 32'd0;
            default:       return 32'($urandom_range(0, 131072)) - 32'd65536;
        endcase
    endfunction

    function automatic logic [255:0] random_cell();
        logic [255:0] d;
        for (int i = 0; i < 8; i++)
            d[32*i +: 32] = pick_value();
        // Keep the velocity component of the denominator mostly nonzero
        if (d[63:32] == 0 && $urandom_range(0, 3) != 0)
            d[63:32] = 32'h0001_0000;
        return d;
    endfunction

    initial
    begin
        logic [255:0] d;
        logic [CFG_W-1:0] gammas[6];
        logic [CFG_W-1:0] widths[6];
        gammas = '{31'd87381, 31'd65536, 31'd262144, 31'd131072, 31'd65536, 31'd200000};
        widths = '{31'd65536, 31'd1, 31'h7fff_ffff, 31'd0, 31'd32768, 31'd9000};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners with reset register values
        send_cell('0);
        send_cell({8{32'h7fff_ffff}});
        send_cell({8{32'h8000_0000}});
        send_cell({8{32'h0001_0000}});
        send_cell({8{32'hffff_0000}});
        // zero middle velocity forces a zero denominator
        send_cell({32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                   32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000});
        // large negative energy makes the radicand negative
        send_cell({32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
        send_cell({32'h8000_0000, 32'h0, 32'h0, 32'hffff_0000,
                   32'h0, 32'h0, 32'hffff_0000, 32'h0});
        send_cell({32'h0000_8000, 32'h0002_0000, 32'hfffe_0000, 32'h0001_8000,
                   32'hffff_8000, 32'h0000_4000, 32'h0003_0000, 32'h0000_0001});
        send_cell({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        send_cell({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0});
        for (int i = 0; i < 8; i++)
        begin
            d = '0;
            d[63:32] = 32'h0001_0000;
            d[32*i +: 32] = 32'h7fff_ffff;
            send_cell(d);
        end
        drain();

        // Random phases across register settings and idle patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_HEAT_RATIO, ph < 6 ? gammas[ph] : 31'($urandom_range(65536, 262144)));
            write_reg(CFG_CELL_WIDTH, ph < 6 ? widths[ph] : 31'($urandom_range(1, 32'h7fff_ffff)));
            cfg_we <= 1'b0;
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            if (ph == 4)
                hold_request = 1'b1;
            for (int n = 0; n < 160; n++)
                send_cell(random_cell());
            drain();
        end

        repeat (150) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
